// ----- sv/pnpc_pkg.sv -----
// Shared constants, codes and types of the polygon near-plane clipper.
`default_nettype none

package pnpc_pkg;

   // Vertex and fixed-point format
   localparam int COORD_W     = 32;
   localparam int NUM_COORD   = 3;
   localparam int COORD_IDX_W = $clog2(NUM_COORD);
   localparam int FRAC_BITS   = 16;

   // Signed difference of two coordinates, and the divisor dp + dc
   localparam int DIFF_W = COORD_W + 1;
   localparam int SUM_W  = COORD_W + 1;

   // Blend factor s lies in [0, 2^FRAC_BITS]
   localparam int S_W        = FRAC_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(S_W + 1);
   localparam int PROD_W     = DIFF_W + S_W + 1;

   // Vertex count per polygon, saturating
   localparam int MAX_VERTICES  = 1024;
   localparam int COUNT_W       = 12;
   localparam int COUNT_CAP_INT = (2 * MAX_VERTICES > (1 << COUNT_W) - 1) ?
                                  (1 << COUNT_W) - 1 : 2 * MAX_VERTICES;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);
   localparam logic [COUNT_W-1:0] KEEP_MIN  = COUNT_W'(2);

   // Stream payload widths
   localparam int REQ_TDATA_W = 3 * COORD_W;
   localparam int RSP_FIELD_W = 3 * COORD_W + COUNT_W + 1;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Register map
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_MIN_DEPTH = 1'b0;

   // Result kinds
   localparam logic KIND_VERTEX  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Divider request and status
   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] dividend;
      logic [SUM_W-1:0]   divisor;
   } div_ctl_type;

   typedef struct packed {
      logic           busy;
      logic           done;
      logic [S_W-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

// ----- sv/polygon_near_plane_clipper_top.sv -----
// Top level of the polygon near-plane clipper: sequencer, blend unit and ports.
//
//   channel  | direction | handshake                 | contents
//   ---------+-----------+---------------------------+-------------------------------------
//   req_     | in        | tvalid / tready           | one vertex; tlast = final vertex
//   rsp_     | out       | tvalid / tready           | clipped vertex or polygon summary
//   csr_     | in/out    | APB, pready tied high     | min_depth at byte address 0
//
// A request that opens a polygon, unless it is also its final vertex, is only stored; each
// later edge is classified, and an edge that crosses the plane runs the bit-serial divider
// and then the shared multiplier before its results go out through the output register.
// req_tready is high only while the sequencer is idle.
// Reset is synchronous and clears the sequencer, the polygon state and the output valid.
// A stalled rsp_ side holds the sequencer in its emit or summary step; no result is dropped.
`default_nettype none

module polygon_near_plane_clipper_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: vert_x [31:0], vert_y [63:32], vert_z [95:64]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [pnpc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                              req_tlast,
   // rsp_tdata: out_x [31:0], out_y [63:32], out_z [95:64], vertex_total [107:96],
   //            keep_polygon [108], zero fill [111:109]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [pnpc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // rsp_tuser: item_kind [0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pnpc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pnpc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pnpc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_EDGE     = 7'b0000010,
      ST_DIV      = 7'b0000100,
      ST_MUL      = 7'b0001000,
      ST_EMIT_X   = 7'b0010000,
      ST_EMIT_CUR = 7'b0100000,
      ST_SUMMARY  = 7'b1000000
   } state_type;

   localparam logic [pnpc_pkg::COORD_IDX_W-1:0] MUL_LAST =
      pnpc_pkg::COORD_IDX_W'(pnpc_pkg::NUM_COORD);
   localparam logic signed [pnpc_pkg::PROD_W-1:0] ROUND_HALF =
      pnpc_pkg::PROD_W'(1) <<< (pnpc_pkg::FRAC_BITS - 1);
   localparam int ZZ = pnpc_pkg::NUM_COORD - 1;

   state_type state_ff;
   state_type state_in;

   logic signed [pnpc_pkg::COORD_W-1:0] min_depth_ff;
   logic signed [pnpc_pkg::COORD_W-1:0] first_ff [pnpc_pkg::NUM_COORD];
   logic signed [pnpc_pkg::COORD_W-1:0] prior_ff [pnpc_pkg::NUM_COORD];
   logic signed [pnpc_pkg::COORD_W-1:0] cur_ff   [pnpc_pkg::NUM_COORD];
   logic signed [pnpc_pkg::COORD_W-1:0] ea_ff    [pnpc_pkg::NUM_COORD];
   logic signed [pnpc_pkg::COORD_W-1:0] eb_ff    [pnpc_pkg::NUM_COORD];
   logic signed [pnpc_pkg::COORD_W-1:0] cx_ff    [pnpc_pkg::NUM_COORD];
   logic signed [pnpc_pkg::COORD_W-1:0] req_coord [pnpc_pkg::NUM_COORD];

   logic                          inside_ff;
   logic                          last_ff;
   logic                          closing_ff;
   logic                          cur_in_ff;
   logic [pnpc_pkg::COUNT_W-1:0]  count_ff;
   logic [pnpc_pkg::COORD_IDX_W-1:0] mul_idx_ff;

   logic signed [pnpc_pkg::PROD_W-1:0]  prod_ff;
   logic signed [pnpc_pkg::COORD_W-1:0] asel_ff;

   logic                               rsp_valid_ff;
   logic [pnpc_pkg::RSP_TDATA_W-1:0]   rsp_data_ff;
   logic                               rsp_user_ff;
   logic                               rsp_last_ff;

   logic req_accept;
   logic out_free;
   logic edge_done;
   logic edge_close;
   logic load_cross;
   logic load_cur;
   logic load_sum;
   logic csr_write;
   logic div_start;

   logic                               a_in;
   logic                               b_in;
   logic                               crossing;
   logic signed [pnpc_pkg::DIFF_W-1:0] da;
   logic signed [pnpc_pkg::DIFF_W-1:0] dc_diff;
   logic [pnpc_pkg::DIFF_W-1:0]        da_mag;
   logic [pnpc_pkg::DIFF_W-1:0]        dc_mag;

   logic [pnpc_pkg::COORD_IDX_W-1:0]    mul_sel;
   logic signed [pnpc_pkg::DIFF_W-1:0]  coord_diff;
   logic signed [pnpc_pkg::PROD_W-1:0]  prod;
   logic signed [pnpc_pkg::PROD_W-1:0]  rounded;
   logic signed [pnpc_pkg::PROD_W-1:0]  shifted;
   logic signed [pnpc_pkg::COORD_W-1:0] blend;

   pnpc_pkg::div_ctl_type  div_ctl;
   pnpc_pkg::div_stat_type div_stat;

   // Unpack the request coordinates
   always_comb begin
      for (int i = 0; i < pnpc_pkg::NUM_COORD; i++) begin
         req_coord[i] = req_tdata[i*pnpc_pkg::COORD_W +: pnpc_pkg::COORD_W];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Classify the current edge and form the plane distances
   always_comb begin
      a_in     = ea_ff[ZZ] >= min_depth_ff;
      b_in     = eb_ff[ZZ] >= min_depth_ff;
      crossing = a_in != b_in;
      da       = pnpc_pkg::DIFF_W'(ea_ff[ZZ]) - pnpc_pkg::DIFF_W'(min_depth_ff);
      dc_diff  = pnpc_pkg::DIFF_W'(eb_ff[ZZ]) - pnpc_pkg::DIFF_W'(min_depth_ff);
      da_mag   = da[pnpc_pkg::DIFF_W-1] ? pnpc_pkg::DIFF_W'(-da) : pnpc_pkg::DIFF_W'(da);
      dc_mag   = dc_diff[pnpc_pkg::DIFF_W-1] ? pnpc_pkg::DIFF_W'(-dc_diff) :
                                               pnpc_pkg::DIFF_W'(dc_diff);
      div_ctl.start    = div_start;
      div_ctl.dividend = da_mag[pnpc_pkg::COORD_W-1:0];
      div_ctl.divisor  = pnpc_pkg::SUM_W'(da_mag[pnpc_pkg::COORD_W-1:0]) +
                         pnpc_pkg::SUM_W'(dc_mag[pnpc_pkg::COORD_W-1:0]);
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      edge_done  = 1'b0;
      load_cross = 1'b0;
      load_cur   = 1'b0;
      load_sum   = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (inside_ff || req_tlast)) state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (crossing) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (b_in) begin
               state_in = ST_EMIT_CUR;
            end else begin
               edge_done = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_idx_ff == MUL_LAST) state_in = ST_EMIT_X;
         end
         ST_EMIT_X: begin
            if (out_free) begin
               load_cross = 1'b1;
               if (cur_in_ff) state_in = ST_EMIT_CUR;
               else edge_done = 1'b1;
            end
         end
         ST_EMIT_CUR: begin
            if (out_free) begin
               load_cur  = 1'b1;
               edge_done = 1'b1;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               load_sum = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // After an edge: clip the closing edge, report the polygon, or wait
      edge_close = edge_done && !closing_ff && last_ff;
      if (edge_done) begin
         if (edge_close) state_in = ST_EDGE;
         else if (last_ff) state_in = ST_SUMMARY;
         else state_in = ST_IDLE;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         inside_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (req_accept && !inside_ff) begin
            inside_ff <= 1'b1;
            count_ff  <= '0;
         end
         if ((load_cross || load_cur) && count_ff < pnpc_pkg::COUNT_CAP) begin
            count_ff <= count_ff + pnpc_pkg::COUNT_W'(1);
         end
         if (load_sum) begin
            inside_ff <= 1'b0;
            count_ff  <= '0;
         end
      end
   end

   // Capture the vertex and set up the edge it opens
   always_ff @(posedge clock) begin
      if (req_accept) begin
         last_ff <= req_tlast;
         for (int i = 0; i < pnpc_pkg::NUM_COORD; i++) begin
            cur_ff[i]   <= req_coord[i];
            prior_ff[i] <= req_coord[i];
            if (!inside_ff) first_ff[i] <= req_coord[i];
            ea_ff[i] <= inside_ff ? prior_ff[i] : req_coord[i];
            eb_ff[i] <= req_coord[i];
         end
         closing_ff <= !inside_ff;
      end else if (edge_close) begin
         for (int i = 0; i < pnpc_pkg::NUM_COORD; i++) begin
            ea_ff[i] <= cur_ff[i];
            eb_ff[i] <= first_ff[i];
         end
         closing_ff <= 1'b1;
      end
      if (state_ff == ST_EDGE) cur_in_ff <= b_in;
   end

   // Shared blend unit: prior + round(s * (cur - prior) / 2^F), one coordinate a cycle
   always_comb begin
      mul_sel    = (mul_idx_ff == MUL_LAST) ? '0 : mul_idx_ff;
      coord_diff = pnpc_pkg::DIFF_W'(eb_ff[mul_sel]) - pnpc_pkg::DIFF_W'(ea_ff[mul_sel]);
      prod       = pnpc_pkg::PROD_W'(coord_diff) *
                   pnpc_pkg::PROD_W'($signed({1'b0, div_stat.quotient}));
      rounded    = prod_ff + ROUND_HALF;
      shifted    = rounded >>> pnpc_pkg::FRAC_BITS;
      blend      = asel_ff + shifted[pnpc_pkg::COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         mul_idx_ff <= '0;
      end else if (state_ff == ST_MUL) begin
         mul_idx_ff <= mul_idx_ff + pnpc_pkg::COORD_IDX_W'(1);
         prod_ff    <= prod;
         asel_ff    <= ea_ff[mul_sel];
         if (mul_idx_ff != '0) begin
            cx_ff[mul_idx_ff - pnpc_pkg::COORD_IDX_W'(1)] <= blend;
         end
      end
   end

   // Output register: hold a result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_cross || load_cur || load_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_cross) begin
         rsp_data_ff <= pnpc_pkg::RSP_TDATA_W'({cx_ff[2], cx_ff[1], cx_ff[0]});
         rsp_user_ff <= pnpc_pkg::KIND_VERTEX;
         rsp_last_ff <= 1'b0;
      end else if (load_cur) begin
         rsp_data_ff <= pnpc_pkg::RSP_TDATA_W'({eb_ff[2], eb_ff[1], eb_ff[0]});
         rsp_user_ff <= pnpc_pkg::KIND_VERTEX;
         rsp_last_ff <= 1'b0;
      end else if (load_sum) begin
         rsp_data_ff <= pnpc_pkg::RSP_TDATA_W'({count_ff > pnpc_pkg::KEEP_MIN, count_ff,
                                                {pnpc_pkg::REQ_TDATA_W{1'b0}}});
         rsp_user_ff <= pnpc_pkg::KIND_SUMMARY;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_depth_ff <= '0;
      end else if (csr_write && csr_paddr[2] == pnpc_pkg::REG_MIN_DEPTH) begin
         min_depth_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == pnpc_pkg::REG_MIN_DEPTH) ? min_depth_ff : '0;

   pnpc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .div_stat (div_stat)
   );

   // Checks
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_tready)
      else $error("request accepted while the divider runs");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pnpc_pkg::COUNT_CAP)
      else $error("vertex count beyond its cap");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> div_stat.quotient <= (pnpc_pkg::S_W'(1) << pnpc_pkg::FRAC_BITS))
      else $error("blend factor above one");

   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == pnpc_pkg::KIND_SUMMARY) |->
         (rsp_tlast && (rsp_tdata[108] == (rsp_tdata[107:96] > pnpc_pkg::KEEP_MIN))))
      else $error("malformed polygon summary");

endmodule

`default_nettype wire

// ----- sv/pnpc_divider.sv -----
// Radix-2 restoring divider that forms the blend factor s = dp * 2^F / (dp + dc).
`default_nettype none

module pnpc_divider (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pnpc_pkg::div_ctl_type  div_ctl,
   output pnpc_pkg::div_stat_type      div_stat
);

   logic [pnpc_pkg::SUM_W-1:0]     rem_ff;
   logic [pnpc_pkg::SUM_W-1:0]     divisor_ff;
   logic [pnpc_pkg::S_W-1:0]       quot_ff;
   logic [pnpc_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           first_ff;
   logic                           done_ff;

   logic [pnpc_pkg::SUM_W:0] trial;
   logic [pnpc_pkg::SUM_W:0] trial_diff;
   logic                     fits;

   // Shift the partial remainder, except on the integer quotient bit
   always_comb begin
      trial      = first_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
   end

   // Control: one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_ctl.start) begin
            busy_ff  <= 1'b1;
            first_ff <= 1'b1;
            cnt_ff   <= pnpc_pkg::DIV_CNT_W'(pnpc_pkg::S_W);
         end else if (busy_ff) begin
            first_ff <= 1'b0;
            cnt_ff   <= cnt_ff - pnpc_pkg::DIV_CNT_W'(1);
            if (cnt_ff == pnpc_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: subtract when the divisor fits, keep the quotient after the run
   always_ff @(posedge clock) begin
      if (div_ctl.start) begin
         rem_ff     <= pnpc_pkg::SUM_W'(div_ctl.dividend);
         divisor_ff <= div_ctl.divisor;
         quot_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? trial_diff[pnpc_pkg::SUM_W-1:0] : trial[pnpc_pkg::SUM_W-1:0];
         quot_ff <= {quot_ff[pnpc_pkg::S_W-2:0], fits};
      end
   end

   assign div_stat.busy     = busy_ff;
   assign div_stat.done     = done_ff;
   assign div_stat.quotient = quot_ff;

endmodule

`default_nettype wire
